// File: src/orcr_pkg.sv
// shared constants and control types for the in-order completion ring
package orcr_pkg;

  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int TAG_BITS   = 16;
  localparam int CMD_W      = 2;
  localparam int STS_W      = 2;
  localparam int CNT_W      = 7;

  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd3;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STS_W-1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic ld_in;
    logic exec;
    logic scan_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             scan_more;
    logic             out_free;
  } dp_sts_t;

endpackage

// File: src/orcr_ram.sv
// generic single write port, single read port ram with registered read
module orcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/orcr_ctrl.sv
// controller state machine sequencing one command at a time
module orcr_ctrl
  import orcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t dcmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    dcmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.ld_in = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        dcmd.exec = 1'b1;
        state_nxt = (sts.cmd == CMD_COMPLETE) ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        // one done mark per cycle until the run ends
        if (sts.scan_more) begin
          dcmd.scan_step = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          dcmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/orcr_dp.sv
// datapath: ring pointers, done marks, tag ram and result register
module orcr_dp
  import orcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             dcmd,
  output dp_sts_t             sts,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TAG_BITS-1:0] in_job_tag,
  input  logic [PTR_W-1:0]    in_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STS_W-1:0]    out_status,
  output logic [PTR_W-1:0]    out_slot_out,
  output logic [TAG_BITS-1:0] out_tag_out,
  output logic [PTR_W-1:0]    out_retired_first,
  output logic [CNT_W-1:0]    out_retired_count,
  output logic                out_all_retired
);

  logic [CMD_W-1:0]    cmd_q_r;
  logic [TAG_BITS-1:0] tag_q_r;
  logic [PTR_W-1:0]    slot_q_r;

  logic [PTR_W-1:0]      alloc_r, disp_r, ret_r;
  logic                  fin_r;
  logic [RING_DEPTH-1:0] done_r;

  logic [STS_W-1:0] res_status_r;
  logic [PTR_W-1:0] res_slot_r, res_first_r;
  logic [CNT_W-1:0] res_count_r;
  logic             take_ok_r;
  logic             out_valid_r;

  logic                ram_we, ram_re;
  logic [TAG_BITS-1:0] ram_rdata;
  logic [PTR_W-1:0]    alloc_inc, slot_dist, disp_dist;
  logic                is_full, is_empty, in_flight;

  assign alloc_inc = alloc_r + PTR_W'(1);
  assign is_full   = (alloc_inc == ret_r);
  assign is_empty  = (disp_r == alloc_r);
  // forward distances around the ring wrap in pointer width
  assign slot_dist = slot_q_r - ret_r;
  assign disp_dist = disp_r - ret_r;
  assign in_flight = (slot_dist < disp_dist);

  assign ram_we = dcmd.exec && (cmd_q_r == CMD_ADD) && !fin_r && !is_full;
  assign ram_re = dcmd.exec && (cmd_q_r == CMD_TAKE) && !is_empty;

  orcr_ram #(
    .WIDTH(TAG_BITS),
    .DEPTH(RING_DEPTH)
  ) u_tags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(alloc_r),
    .wdata(tag_q_r),
    .re   (ram_re),
    .raddr(disp_r),
    .rdata(ram_rdata)
  );

  assign sts.cmd       = cmd_q_r;
  assign sts.scan_more = (ret_r != disp_r) && done_r[ret_r];
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (dcmd.ld_in) begin
      cmd_q_r  <= in_cmd;
      tag_q_r  <= in_job_tag;
      slot_q_r <= in_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      disp_r  <= '0;
      ret_r   <= '0;
      fin_r   <= 1'b0;
      done_r  <= '0;
    end else begin
      if (dcmd.exec) begin
        case (cmd_q_r)
          CMD_ADD: begin
            if (ram_we) begin
              done_r[alloc_r] <= 1'b0;
              alloc_r         <= alloc_inc;
            end
          end
          CMD_TAKE: begin
            if (ram_re) begin
              disp_r <= disp_r + PTR_W'(1);
            end
          end
          CMD_COMPLETE: begin
            if (in_flight) begin
              done_r[slot_q_r] <= 1'b1;
            end
          end
          CMD_FINISH: fin_r <= 1'b1;
          default: ;
        endcase
      end
      if (dcmd.scan_step) begin
        ret_r <= ret_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.exec) begin
      res_slot_r  <= '0;
      res_first_r <= ret_r;
      res_count_r <= '0;
      take_ok_r   <= 1'b0;
      case (cmd_q_r)
        CMD_ADD: begin
          if (fin_r) begin
            res_status_r <= ST_EXHAUSTED;
          end else if (is_full) begin
            res_status_r <= ST_FULL;
          end else begin
            res_status_r <= ST_OK;
            res_slot_r   <= alloc_r;
          end
        end
        CMD_TAKE: begin
          if (is_empty) begin
            res_status_r <= fin_r ? ST_EXHAUSTED : ST_EMPTY;
          end else begin
            res_status_r <= ST_OK;
            res_slot_r   <= disp_r;
            take_ok_r    <= 1'b1;
          end
        end
        default: res_status_r <= ST_OK;
      endcase
    end else if (dcmd.scan_step) begin
      res_count_r <= res_count_r + CNT_W'(1);
    end
  end

  // result register parts the output handshake from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dcmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.emit) begin
      out_status        <= res_status_r;
      out_slot_out      <= res_slot_r;
      out_tag_out       <= take_ok_r ? ram_rdata : '0;
      out_retired_first <= (res_count_r != '0) ? res_first_r : '0;
      out_retired_count <= res_count_r;
      out_all_retired   <= fin_r && (ret_r == alloc_r);
    end
  end

  assign out_valid = out_valid_r;

  a_disp_within_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (disp_r - ret_r) <= (alloc_r - ret_r))
    else $error("dispatch pointer ran past alloc pointer");

  a_scan_stays_behind: assert property (@(posedge clk) disable iff (!rst_n)
    dcmd.scan_step |-> (ret_r != disp_r) && done_r[ret_r])
    else $error("retire scan stepped past dispatch or an open slot");

  a_finish_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r)
    else $error("finished mark cleared without reset");

  a_full_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    dcmd.emit && (res_status_r == ST_FULL) |-> (cmd_q_r == CMD_ADD))
    else $error("full status for a command other than add");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dcmd.ld_in, dcmd.exec, dcmd.scan_step, dcmd.emit}))
    else $error("more than one sequencer action in a cycle");

endmodule

// File: src/in_order_completion_ring_core.sv
// top level of the in-order completion ring
//
// input channel in_valid/in_ready carries one command (in_cmd: add, take,
// complete, finish) with in_job_tag and in_slot; each command gives exactly
// one result on out_valid/out_ready with status, slot, tag, retired run
// and the all-retired flag.
// one command is worked on at a time. after the input transfer the block
// executes the command, then for complete scans the done marks, retiring
// the run of done slots one slot a cycle, then loads the result register
// once it is free. a take reads its tag from the tag ram, whose read data
// is registered. the result register lets the next command be accepted
// while the last result waits; if the receiver stalls, the following
// result waits in the datapath, the sequencer stays in its emit state and
// in_ready stays low until the register frees up.
// reset (rst_n low, synchronous) empties the ring: pointers zero, done
// marks cleared, finished clear, no result pending. no clearing pass.
module in_order_completion_ring_core
  import orcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TAG_BITS-1:0] in_job_tag,
  input  logic [PTR_W-1:0]    in_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STS_W-1:0]    out_status,
  output logic [PTR_W-1:0]    out_slot_out,
  output logic [TAG_BITS-1:0] out_tag_out,
  output logic [PTR_W-1:0]    out_retired_first,
  output logic [CNT_W-1:0]    out_retired_count,
  output logic                out_all_retired
);

  dp_cmd_t dcmd;
  dp_sts_t sts;

  orcr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .dcmd    (dcmd)
  );

  orcr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .dcmd             (dcmd),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_job_tag       (in_job_tag),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_tag_out      (out_tag_out),
    .out_retired_first(out_retired_first),
    .out_retired_count(out_retired_count),
    .out_all_retired  (out_all_retired)
  );

endmodule

// File: sim/tb_in_order_completion_ring_core.sv
// testbench for the in-order completion ring: random job traffic checked against a ring predictor
`timescale 1ns / 100ps

module tb_in_order_completion_ring_core
  import orcr_pkg::*;
();

  localparam int ORDER_FWD  = 0;
  localparam int ORDER_REV  = 1;
  localparam int ORDER_SHUF = 2;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [TAG_BITS-1:0] tag;
    logic [PTR_W-1:0]    slot;
  } ring_cmd_t;

  typedef struct packed {
    logic [STS_W-1:0]    status;
    logic [PTR_W-1:0]    slot;
    logic [TAG_BITS-1:0] tag;
    logic [PTR_W-1:0]    first;
    logic [CNT_W-1:0]    count;
    logic                all_ret;
  } ring_result_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd     = CMD_ADD;
  logic [TAG_BITS-1:0] in_job_tag = '0;
  logic [PTR_W-1:0]    in_slot    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [STS_W-1:0]    out_status;
  logic [PTR_W-1:0]    out_slot_out;
  logic [TAG_BITS-1:0] out_tag_out;
  logic [PTR_W-1:0]    out_retired_first;
  logic [CNT_W-1:0]    out_retired_count;
  logic                out_all_retired;

  // predictor state
  logic                done_mark [RING_DEPTH];
  logic [TAG_BITS-1:0] tag_mem [RING_DEPTH];
  logic [PTR_W-1:0]    alloc_p = '0;
  logic [PTR_W-1:0]    disp_p  = '0;
  logic [PTR_W-1:0]    ret_p   = '0;
  logic                fin     = 1'b0;

  ring_cmd_t    cmd_fifo [$];
  ring_result_t awaited_results [$];
  ring_cmd_t    drv_item;
  ring_result_t want, got;
  string        bad;

  int  n_sent = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  mismatches = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  no_idle = 1'b0;
  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;

  in_order_completion_ring_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_job_tag        (in_job_tag),
    .in_slot           (in_slot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_tag_out       (out_tag_out),
    .out_retired_first (out_retired_first),
    .out_retired_count (out_retired_count),
    .out_all_retired   (out_all_retired)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      done_mark[i] = 1'b0;
      tag_mem[i]   = '0;
    end
  end

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % RING_DEPTH);
  endfunction

  // forward distance around the ring
  function automatic int ring_dist(input logic [PTR_W-1:0] from, input logic [PTR_W-1:0] to);
    return (int'(to) + RING_DEPTH - int'(from)) % RING_DEPTH;
  endfunction

  function automatic ring_result_t apply_ring_cmd(input ring_cmd_t c);
    ring_result_t     r;
    logic [PTR_W-1:0] start;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_ADD: begin
        if (fin) begin
          r.status = ST_EXHAUSTED;
        end else if (ring_inc(alloc_p) == ret_p) begin
          r.status = ST_FULL;
        end else begin
          tag_mem[alloc_p]   = c.tag;
          done_mark[alloc_p] = 1'b0;
          r.slot  = alloc_p;
          alloc_p = ring_inc(alloc_p);
        end
      end
      CMD_TAKE: begin
        if (disp_p == alloc_p) begin
          r.status = fin ? ST_EXHAUSTED : ST_EMPTY;
        end else begin
          r.slot = disp_p;
          r.tag  = tag_mem[disp_p];
          disp_p = ring_inc(disp_p);
        end
      end
      CMD_COMPLETE: begin
        start = ret_p;
        if (ring_dist(ret_p, c.slot) < ring_dist(ret_p, disp_p)) done_mark[c.slot] = 1'b1;
        while (ret_p != disp_p && done_mark[ret_p]) begin
          ret_p   = ring_inc(ret_p);
          r.count = r.count + CNT_W'(1);
        end
        if (r.count != 0) r.first = start;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    r.all_ret = fin && (ret_p == alloc_p);
    return r;
  endfunction

  // sample both channels; the result is checked before the new command is predicted
  always @(posedge clk) begin
    in_xfer  <= rst_n && in_valid && in_ready;
    out_xfer <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      got = ring_result_t'{out_status, out_slot_out, out_tag_out, out_retired_first,
                           out_retired_count, out_all_retired};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR %0t: result with nothing outstanding", $time);
      end else begin
        want = awaited_results.pop_front();
        bad = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.slot !== want.slot) bad = {bad, " slot_out"};
        if (got.tag !== want.tag) bad = {bad, " tag_out"};
        if (got.first !== want.first) bad = {bad, " retired_first"};
        if (got.count !== want.count) bad = {bad, " retired_count"};
        if (got.all_ret !== want.all_ret) bad = {bad, " all_retired"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR %0t: result %0d, bad field(s):%s", $time, n_checked, bad);
            $display("  exp sts=%0d slot=%0d tag=%h first=%0d cnt=%0d all=%0b",
                     want.status, want.slot, want.tag, want.first, want.count, want.all_ret);
            $display("  got sts=%0d slot=%0d tag=%h first=%0d cnt=%0d all=%0b",
                     got.status, got.slot, got.tag, got.first, got.count, got.all_ret);
          end
        end
      end
      n_checked <= n_checked + 1;
    end
    if (rst_n && in_valid && in_ready) begin
      awaited_results.push_back(apply_ring_cmd(ring_cmd_t'{in_cmd, in_job_tag, in_slot}));
      n_accepted <= n_accepted + 1;
    end
  end

  // command driver
  always @(negedge clk) begin
    if (in_xfer) send_gap = no_idle ? 0 : $urandom_range(0, 9);
    if (in_valid && !in_xfer) begin
      // hold until the transfer
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (cmd_fifo.size() != 0) begin
      drv_item = cmd_fifo.pop_front();
      in_cmd     <= drv_item.cmd;
      in_job_tag <= drv_item.tag;
      in_slot    <= drv_item.slot;
      in_valid   <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver with random stalls after each transfer
  always @(negedge clk) begin
    if (out_xfer) recv_stall = no_idle ? 0 : $urandom_range(0, 9);
    if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic issue(input logic [CMD_W-1:0] c, input logic [TAG_BITS-1:0] t,
                       input logic [PTR_W-1:0] s);
    cmd_fifo.push_back(ring_cmd_t'{c, t, s});
    n_sent++;
    wait (n_accepted == n_sent);
  endtask

  // complete every dispatched slot not yet marked done
  task automatic complete_inflight(input int order);
    logic [PTR_W-1:0] slots [$];
    logic [PTR_W-1:0] tmp;
    int               j;
    int               span;
    slots = {};
    span = ring_dist(ret_p, disp_p);
    for (int k = 0; k < span; k++) begin
      tmp = PTR_W'((int'(ret_p) + k) % RING_DEPTH);
      if (!done_mark[tmp]) slots.push_back(tmp);
    end
    if (order == ORDER_SHUF) begin
      for (int i = slots.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = slots[i];
        slots[i] = slots[j];
        slots[j] = tmp;
      end
    end
    for (int i = 0; i < slots.size(); i++) begin
      tmp = (order == ORDER_REV) ? slots[slots.size() - 1 - i] : slots[i];
      issue(CMD_COMPLETE, TAG_BITS'($urandom), tmp);
    end
  endtask

  initial begin : stim
    int               random_end;
    int               len;
    int               add_w;
    int               pick;
    int               k;
    logic [CMD_W-1:0] c;
    bit               first_ep;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    issue(CMD_TAKE, '1, '1);                  // take on an empty ring
    issue(CMD_COMPLETE, '0, '0);              // complete with nothing in flight
    issue(CMD_ADD, '0, '0);
    issue(CMD_ADD, '1, '1);
    issue(CMD_ADD, 16'ha5a5, 7'h2a);
    issue(CMD_TAKE, '0, '0);
    issue(CMD_TAKE, '0, '0);
    issue(CMD_COMPLETE, '0, 7'd1);            // out of order, nothing retires
    issue(CMD_COMPLETE, '0, 7'd2);            // allocated but not handed out
    issue(CMD_COMPLETE, '1, 7'd127);          // far outside the window
    issue(CMD_COMPLETE, '0, 7'd0);            // retires the run of two
    issue(CMD_COMPLETE, '0, 7'd1);            // already retired
    issue(CMD_TAKE, '0, '0);
    issue(CMD_COMPLETE, 16'h5a5a, 7'd2);
    issue(CMD_TAKE, 16'h1234, 7'h55);

    random_end = n_sent + RANDOM_ITEMS;
    first_ep = 1'b1;
    while (n_sent < random_end) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (first_ep || $urandom_range(0, 7) == 0) begin
        // let everything drain, fill the ring to the brim and overrun it, then take and complete every slot
        wait (n_checked >= n_sent);
        while (ring_inc(alloc_p) != ret_p) issue(CMD_ADD, TAG_BITS'($urandom), PTR_W'($urandom));
        repeat ($urandom_range(1, 2)) issue(CMD_ADD, TAG_BITS'($urandom), PTR_W'($urandom));
        while (disp_p != alloc_p) issue(CMD_TAKE, TAG_BITS'($urandom), PTR_W'($urandom));
        issue(CMD_TAKE, TAG_BITS'($urandom), PTR_W'($urandom));
        complete_inflight(first_ep ? ORDER_REV : ORDER_SHUF);
        first_ep = 1'b0;
      end else begin
        len = $urandom_range(10, 80);
        case ($urandom_range(0, 2))
          0: add_w = 25;
          1: add_w = 35;
          default: add_w = 55;
        endcase
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            // noise: any command but finish, random fields
            case ($urandom_range(0, 2))
              0: c = CMD_ADD;
              1: c = CMD_TAKE;
              default: c = CMD_COMPLETE;
            endcase
            issue(c, TAG_BITS'($urandom), PTR_W'($urandom));
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < add_w) begin
              issue(CMD_ADD, TAG_BITS'($urandom), PTR_W'($urandom));
            end else if (pick < add_w + 30 && disp_p != alloc_p) begin
              issue(CMD_TAKE, TAG_BITS'($urandom), PTR_W'($urandom));
            end else if (ret_p != disp_p) begin
              // oldest in flight half the time, else anywhere in the window
              k = $urandom_range(0, 1) ? 0 : $urandom_range(0, ring_dist(ret_p, disp_p) - 1);
              issue(CMD_COMPLETE, TAG_BITS'($urandom), PTR_W'((int'(ret_p) + k) % RING_DEPTH));
            end else if (disp_p != alloc_p) begin
              issue(CMD_TAKE, TAG_BITS'($urandom), PTR_W'($urandom));
            end else begin
              issue(CMD_ADD, TAG_BITS'($urandom), PTR_W'($urandom));
            end
          end
        end
        if ($urandom_range(0, 3) == 0) wait (n_checked >= n_sent);
      end
    end

    // wind down: finish with work still in flight
    no_idle = 1'b0;
    repeat (3) issue(CMD_ADD, TAG_BITS'($urandom), PTR_W'($urandom));
    issue(CMD_FINISH, TAG_BITS'($urandom), PTR_W'($urandom));
    issue(CMD_ADD, '1, '1);                   // add after finish
    while (disp_p != alloc_p) issue(CMD_TAKE, TAG_BITS'($urandom), PTR_W'($urandom));
    issue(CMD_TAKE, '0, '0);                  // empty after finish
    issue(CMD_FINISH, '1, '1);                // finish again
    complete_inflight(ORDER_SHUF);
    issue(CMD_COMPLETE, TAG_BITS'($urandom), PTR_W'($urandom));
    issue(CMD_TAKE, '0, '0);

    wait (n_checked >= n_sent);
    repeat (RING_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_in_order_completion_ring_core: done, clean");
    end else begin
      $display("tb_in_order_completion_ring_core: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_in_order_completion_ring_core: done, errors");
    $finish;
  end

endmodule

// File: files.f
src/orcr_pkg.sv
src/orcr_ram.sv
src/orcr_ctrl.sv
src/orcr_dp.sv
src/in_order_completion_ring_core.sv
sim/tb_in_order_completion_ring_core.sv
